// File: design/rrsa_pkg.sv
// Shared types and constants for the round-robin slot allocator.
// Holds field widths, opcodes, the sequencer state type and the item structs.
// No dependencies.
package rrsa_pkg;

   // Field widths fixed by the channel layout
   localparam int CFG_W  = 9;
   localparam int SLOT_W = 8;
   localparam int TOT_W  = 9;
   localparam int OP_W   = 2;

   localparam int SLOTS_DEFAULT = 256;
   localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 9'd256;

   // Opcodes carried on the request side
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT    = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic              prefer_active;
      logic [SLOT_W-1:0] slot;
      logic              set_free;
      logic              init_active;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic              found;
      logic [TOT_W-1:0]  used_total;
      logic [TOT_W-1:0]  active_total;
   } result_type;

endpackage

// File: design/round_robin_slot_allocator_core.sv
// Round-robin slot allocator, top level: channels, slot count register and
// output register around the allocation engine.
// Depends on rrsa_pkg and rrsa_engine.
//
// Use: each request item (allocate, release or init) yields exactly one
// response item carrying the granted slot, a found flag and the used and
// active totals after the item. csr_wr_en writes the slot count register;
// write it only while no item is in progress.
// Timing: the engine takes one item at a time. An allocate reads the flag
// memory one slot a cycle from the scan pointer until it finds a matching
// slot or has checked every slot in range. Release and init take one
// read-modify-write; a release or init of an out-of-range slot, or an unused
// opcode, goes straight to the response. The next request is accepted in the
// cycle after the response enters the output register, even while that
// response still waits to be taken.
// Reset: a clearing pass writes every flag entry to zero, with req_tready
// low. The slot count resets to 256, pointer and totals to zero.
// Stall: a finished response waits in the engine while the output register
// holds an untaken one; no item is lost.
module round_robin_slot_allocator_core #(
   parameter int SLOTS = rrsa_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_wr_en,
   input  logic [rrsa_pkg::CFG_W-1:0] csr_wr_data,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,  // prefer_active, slot[7:0], set_free, init_active
   input  logic [1:0]                 req_tuser,  // opcode[1:0]
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // granted_slot[7:0], used_total[8:0], active_total[8:0]
   output logic                       rsp_tuser   // found
);

   logic [rrsa_pkg::CFG_W-1:0] slot_count_ff;
   logic                       rsp_tvalid_ff;
   logic [31:0]                rsp_tdata_ff;
   logic                       rsp_tuser_ff;

   logic                 eng_idle;
   logic                 eng_done;
   logic                 res_ready;
   logic                 req_accept;
   logic                 rsp_load;
   rrsa_pkg::cmd_type    cmd;
   rrsa_pkg::result_type res;

   // Unpack the request item
   assign cmd.opcode        = req_tuser;
   assign cmd.prefer_active = req_tdata[0];
   assign cmd.slot          = req_tdata[8:1];
   assign cmd.set_free      = req_tdata[9];
   assign cmd.init_active   = req_tdata[10];

   assign req_tready = eng_idle;
   assign req_accept = req_tvalid && eng_idle;
   assign res_ready  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load   = eng_done && res_ready;

   // Slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= rrsa_pkg::SLOT_COUNT_RESET;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
      end
   end

   rrsa_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .slot_count (slot_count_ff),
      .start      (req_accept),
      .cmd        (cmd),
      .idle       (eng_idle),
      .done       (eng_done),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Output register: load a finished item, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {6'b0, res.active_total, res.used_total, res.granted_slot};
         rsp_tuser_ff <= res.found;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // The engine goes busy as soon as it takes an item
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted but engine did not leave idle");

   // A miss reports slot zero
   a_miss_slot_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("response without a grant carries a non-zero slot");

   // Totals do not move while no item is in progress
   a_idle_totals_stable : assert property (@(posedge clock) disable iff (reset)
      (eng_idle && $past(eng_idle)) |-> ($stable(res.used_total) && $stable(res.active_total)))
      else $error("totals changed while idle");

   // A finished item waits in the engine while the output register is full
   a_done_held : assert property (@(posedge clock) disable iff (reset)
      (eng_done && !res_ready) |=> eng_done)
      else $error("finished item dropped while output register was full");

endmodule

// File: design/rrsa_engine.sv
// Slot allocation engine: flag memory, scan sequencer, pointer and counts.
// One synchronous memory holds the used and active flags of every slot.
// Depends on rrsa_pkg.
module rrsa_engine #(
   parameter int SLOTS = rrsa_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rrsa_pkg::CFG_W-1:0]  slot_count,
   input  logic                        start,
   input  rrsa_pkg::cmd_type           cmd,
   output logic                        idle,
   output logic                        done,
   input  logic                        res_ready,
   output rrsa_pkg::result_type        res
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

   typedef struct packed {
      logic used;
      logic active;
   } flag_type;

   flag_type flag_mem [SLOTS];
   flag_type rd_data_ff;

   rrsa_pkg::state_type state_ff, state_in;
   rrsa_pkg::cmd_type   cmd_ff, cmd_in;

   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic          chk_last_ff, chk_last_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] active_ff, active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          pref_ff, pref_in;
   logic [rrsa_pkg::SLOT_W-1:0] granted_ff, granted_in;
   logic          found_ff, found_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   flag_type      wr_data;

   logic [CW-1:0] eff_n;
   logic [AW-1:0] start_pos;
   logic [AW-1:0] next_addr;
   logic          slot_ok;
   logic          hit;

   // Clamp the slot count to 1..SLOTS
   always_comb begin
      if (slot_count == '0) begin
         eff_n = CW'(1);
      end else if (32'(slot_count) > 32'(SLOTS)) begin
         eff_n = CW'(SLOTS);
      end else begin
         eff_n = CW'(slot_count);
      end
   end

   // Scan addresses and range checks
   assign start_pos = (CW'(ptr_ff) >= eff_n) ? '0 : ptr_ff;
   assign next_addr = ((CW'(chk_addr_ff) + CW'(1)) < eff_n) ? (chk_addr_ff + AW'(1)) : '0;
   assign slot_ok   = 32'(cmd.slot) < 32'(eff_n);
   assign hit       = !rd_data_ff.used && (!pref_ff || rd_data_ff.active);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrsa_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = rrsa_pkg::ST_IDLE;
            end
         end
         rrsa_pkg::ST_IDLE: begin
            if (start) begin
               case (cmd.opcode)
                  rrsa_pkg::OP_ALLOC: begin
                     state_in = rrsa_pkg::ST_SCAN;
                  end
                  rrsa_pkg::OP_RELEASE, rrsa_pkg::OP_INIT: begin
                     state_in = slot_ok ? rrsa_pkg::ST_MODIFY : rrsa_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = rrsa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         rrsa_pkg::ST_SCAN: begin
            if (hit || chk_last_ff) begin
               state_in = rrsa_pkg::ST_DONE;
            end
         end
         rrsa_pkg::ST_MODIFY: begin
            state_in = rrsa_pkg::ST_DONE;
         end
         rrsa_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = rrsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrsa_pkg::ST_CLEAR;
         end
      endcase
   end

   // Memory accesses and datapath updates per state
   always_comb begin
      cmd_in      = cmd_ff;
      chk_addr_in = chk_addr_ff;
      chk_last_in = chk_last_ff;
      issued_in   = issued_ff;
      ptr_in      = ptr_ff;
      used_in     = used_ff;
      active_in   = active_ff;
      clr_addr_in = clr_addr_ff;
      pref_in     = pref_ff;
      granted_in  = granted_ff;
      found_in    = found_ff;
      rd_en       = 1'b0;
      rd_addr     = chk_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      case (state_ff)
         rrsa_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         rrsa_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in     = cmd;
               granted_in = '0;
               found_in   = 1'b0;
               // preference only counts while the used and active totals differ
               pref_in    = cmd.prefer_active && (used_ff != active_ff);
               rd_en      = 1'b1;
               if (cmd.opcode == rrsa_pkg::OP_ALLOC) begin
                  rd_addr     = start_pos;
                  chk_addr_in = start_pos;
                  chk_last_in = (eff_n == CW'(1));
                  issued_in   = CW'(1);
               end else begin
                  rd_addr = AW'(cmd.slot);
               end
            end
         end
         rrsa_pkg::ST_SCAN: begin
            if (hit) begin
               wr_en      = 1'b1;
               wr_addr    = chk_addr_ff;
               wr_data    = '{used: 1'b1, active: 1'b1};
               used_in    = used_ff + CW'(1);
               active_in  = rd_data_ff.active ? active_ff : (active_ff + CW'(1));
               ptr_in     = next_addr;
               granted_in = rrsa_pkg::SLOT_W'(chk_addr_ff);
               found_in   = 1'b1;
            end else if (!chk_last_ff) begin
               // advance to the next slot, one read a cycle
               rd_en       = 1'b1;
               rd_addr     = next_addr;
               chk_addr_in = next_addr;
               chk_last_in = ((issued_ff + CW'(1)) == eff_n);
               issued_in   = issued_ff + CW'(1);
            end
         end
         rrsa_pkg::ST_MODIFY: begin
            wr_addr = AW'(cmd_ff.slot);
            case (cmd_ff.opcode)
               rrsa_pkg::OP_RELEASE: begin
                  wr_en          = 1'b1;
                  wr_data.used   = 1'b0;
                  wr_data.active = rd_data_ff.active && !cmd_ff.set_free;
                  if (rd_data_ff.used) begin
                     used_in = used_ff - CW'(1);
                  end
                  if (rd_data_ff.active && cmd_ff.set_free) begin
                     active_in = active_ff - CW'(1);
                  end
               end
               rrsa_pkg::OP_INIT: begin
                  wr_en          = 1'b1;
                  wr_data.used   = rd_data_ff.used;
                  wr_data.active = cmd_ff.init_active;
                  if (cmd_ff.init_active && !rd_data_ff.active) begin
                     active_in = active_ff + CW'(1);
                  end else if (!cmd_ff.init_active && rd_data_ff.active) begin
                     active_in = active_ff - CW'(1);
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Flag memory, one write and one registered read a cycle; the write of an
   // item always lands before the next item's first read, with ST_DONE between
   always_ff @(posedge clock) begin
      if (wr_en) begin
         flag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= flag_mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rrsa_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         ptr_ff      <= '0;
         used_ff     <= '0;
         active_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         ptr_ff      <= ptr_in;
         used_ff     <= used_in;
         active_ff   <= active_in;
      end
   end

   // Item payload and scan position
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chk_addr_ff <= chk_addr_in;
      chk_last_ff <= chk_last_in;
      issued_ff   <= issued_in;
      pref_ff     <= pref_in;
      granted_ff  <= granted_in;
      found_ff    <= found_in;
   end

   assign idle = (state_ff == rrsa_pkg::ST_IDLE);
   assign done = (state_ff == rrsa_pkg::ST_DONE);

   assign res.granted_slot = granted_ff;
   assign res.found        = found_ff;
   assign res.used_total   = rrsa_pkg::TOT_W'(used_ff);
   assign res.active_total = rrsa_pkg::TOT_W'(active_ff);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for round_robin_slot_allocator_core.
// Predicts every response from a local copy of the slot flags, pointer and totals;
// depends on rrsa_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int NSLOTS = rrsa_pkg::SLOTS_DEFAULT;
   localparam int QUIET_LIMIT = 5000;
   localparam logic [rrsa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [rrsa_pkg::CFG_W-1:0]   csr_wr_data = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [15:0]                  req_tdata = '0;  // prefer_active, slot[7:0], set_free, init_active
   logic [1:0]                   req_tuser = '0;  // opcode[1:0]
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [31:0]                  rsp_tdata;       // granted_slot[7:0], used_total[8:0], active_total[8:0]
   logic                         rsp_tuser;       // found

   // Predicted state of the allocator
   bit                           used_map [0:NSLOTS-1];
   bit                           active_map [0:NSLOTS-1];
   int unsigned                  next_scan;
   int unsigned                  used_tally;
   int unsigned                  active_tally;
   logic [rrsa_pkg::CFG_W-1:0]   slot_limit;

   rrsa_pkg::result_type         awaited_responses[$];
   int                           mismatches = 0;
   int                           quiet_cycles = 0;
   bit                           req_gaps_on = 1'b1;
   bit                           rsp_stalls_on = 1'b1;

   round_robin_slot_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Slot count clamped to 1..NSLOTS
   function automatic int unsigned effective_slots();
      if (slot_limit == '0) return 1;
      if (32'(slot_limit) > NSLOTS) return NSLOTS;
      return 32'(slot_limit);
   endfunction

   // Apply one item to the predicted state and return the response it yields
   function automatic rrsa_pkg::result_type apply_slot_op(rrsa_pkg::cmd_type c);
      rrsa_pkg::result_type r;
      int unsigned n;
      int unsigned pos;
      int unsigned i;
      bit          pref;
      bit          hit;
      n = effective_slots();
      r = '0;
      hit = 1'b0;
      case (c.opcode)
         rrsa_pkg::OP_ALLOC: begin
            pos = (next_scan >= n) ? 0 : next_scan;
            pref = c.prefer_active && (active_tally != used_tally);
            for (i = 0; i < n && !hit; i++) begin
               if (!used_map[pos] && (!pref || active_map[pos]))
                  hit = 1'b1;
               else
                  pos = (pos + 1 < n) ? pos + 1 : 0;
            end
            if (hit) begin
               if (!used_map[pos]) used_tally++;
               if (!active_map[pos]) active_tally++;
               used_map[pos] = 1'b1;
               active_map[pos] = 1'b1;
               next_scan = (pos + 1 < n) ? pos + 1 : 0;
               r.granted_slot = pos[rrsa_pkg::SLOT_W-1:0];
               r.found = 1'b1;
            end
         end
         rrsa_pkg::OP_RELEASE: begin
            if (c.slot < n) begin
               if (used_map[c.slot]) used_tally--;
               used_map[c.slot] = 1'b0;
               if (c.set_free) begin
                  if (active_map[c.slot]) active_tally--;
                  active_map[c.slot] = 1'b0;
               end
            end
         end
         rrsa_pkg::OP_INIT: begin
            if (c.slot < n) begin
               if (c.init_active && !active_map[c.slot]) active_tally++;
               if (!c.init_active && active_map[c.slot]) active_tally--;
               active_map[c.slot] = c.init_active;
            end
         end
         default: begin
         end
      endcase
      r.used_total = used_tally[rrsa_pkg::TOT_W-1:0];
      r.active_total = active_tally[rrsa_pkg::TOT_W-1:0];
      return r;
   endfunction

   function automatic rrsa_pkg::cmd_type make_cmd(logic [rrsa_pkg::OP_W-1:0] op, bit pref,
                                                  int unsigned s, bit sf, bit ia);
      rrsa_pkg::cmd_type c;
      c.opcode = op;
      c.prefer_active = pref;
      c.slot = s[rrsa_pkg::SLOT_W-1:0];
      c.set_free = sf;
      c.init_active = ia;
      return c;
   endfunction

   // Mostly in-range slots, with the occasional index anywhere in the field
   function automatic rrsa_pkg::cmd_type random_cmd();
      rrsa_pkg::cmd_type c;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)      c.opcode = rrsa_pkg::OP_ALLOC;
      else if (r < 73) c.opcode = rrsa_pkg::OP_RELEASE;
      else if (r < 95) c.opcode = rrsa_pkg::OP_INIT;
      else             c.opcode = OP_UNUSED;
      c.prefer_active = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85)
         c.slot = rrsa_pkg::SLOT_W'($urandom_range(0, effective_slots() - 1));
      else
         c.slot = rrsa_pkg::SLOT_W'($urandom_range(0, 255));
      c.set_free = 1'($urandom_range(0, 1));
      c.init_active = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int draw_gap();
      int unsigned r;
      if (!req_gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < 100)
         $display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Present one item, record its expected response once taken; valid is left
   // high when no gap follows so back-to-back items need no toggle
   task automatic send_item(rrsa_pkg::cmd_type c);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= c.opcode;
      req_tdata <= {5'b0, c.init_active, c.set_free, c.slot, c.prefer_active};
      do @(posedge clock); while (!req_tready);
      awaited_responses.insert(awaited_responses.size(), apply_slot_op(c));
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_slot_count(int unsigned value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[rrsa_pkg::CFG_W-1:0];
      slot_limit = value[rrsa_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Allocation from empty, dropped and honoured preference
   task automatic test_alloc_basics();
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 1, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 10, 0, 1));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 1, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
   endtask

   // Release with and without freeing, repeated init, unused opcode
   task automatic test_release_init();
      send_item(make_cmd(rrsa_pkg::OP_RELEASE, 0, 10, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_RELEASE, 0, 0, 1, 0));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 255, 0, 1));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 255, 0, 1));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 255, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_RELEASE, 0, 200, 1, 0));
      send_item(make_cmd(OP_UNUSED, 1, 255, 1, 1));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 0, 0, 0));
   endtask

   // Narrow range: stale pointer, out-of-range slots, preference with the
   // only active free slot beyond the range, and a full pool
   task automatic test_narrow_range();
      set_slot_count(4);
      send_item(make_cmd(rrsa_pkg::OP_RELEASE, 0, 200, 1, 0));
      send_item(make_cmd(rrsa_pkg::OP_INIT, 0, 200, 0, 1));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 1, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
   endtask

   // Register values outside 1..NSLOTS clamp to the ends
   task automatic test_count_clamp();
      set_slot_count(0);
      send_item(make_cmd(rrsa_pkg::OP_RELEASE, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
      set_slot_count(511);
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 1, 0, 0, 0));
      send_item(make_cmd(rrsa_pkg::OP_ALLOC, 0, 0, 0, 0));
   endtask

   task automatic test_random_phase(int unsigned count_value, int items);
      set_slot_count(count_value);
      req_gaps_on = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      repeat (items) send_item(random_cmd());
   endtask

   task automatic test_random_traffic();
      int unsigned counts[14] = '{1, 2, 3, 5, 8, 13, 32, 100, 256, 0, 511, 300, 64, 7};
      foreach (counts[k]) test_random_phase(counts[k], 102);
   endtask

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      rrsa_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding", 32'(rsp_tdata[7:0]), 0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_tdata[7:0] != want.granted_slot)
               report_mismatch("granted_slot", 32'(rsp_tdata[7:0]), 32'(want.granted_slot));
            if (rsp_tuser != want.found)
               report_mismatch("found", 32'(rsp_tuser), 32'(want.found));
            if (rsp_tdata[16:8] != want.used_total)
               report_mismatch("used_total", 32'(rsp_tdata[16:8]), 32'(want.used_total));
            if (rsp_tdata[25:17] != want.active_total)
               report_mismatch("active_total", 32'(rsp_tdata[25:17]),
                               32'(want.active_total));
         end
      end
   end

   // Pace the response side: stretches of ready, short and long stalls
   initial begin : rsp_pacer
      int hold;
      int unsigned r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!rsp_stalls_on) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(0, 6);
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(20, 80);
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("round_robin_slot_allocator_core verification failed");
         $finish;
      end
   end

   initial begin
      foreach (used_map[k]) begin
         used_map[k] = 1'b0;
         active_map[k] = 1'b0;
      end
      next_scan = 0;
      used_tally = 0;
      active_tally = 0;
      slot_limit = rrsa_pkg::SLOT_COUNT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_alloc_basics();
      test_release_init();
      test_narrow_range();
      test_count_clamp();
      test_random_traffic();

      wait_drained();
      repeat (300) @(posedge clock);
      if (awaited_responses.size() != 0)
         report_mismatch("responses never delivered", 0, awaited_responses.size());
      if (mismatches == 0)
         $display("round_robin_slot_allocator_core verification clean");
      else
         $display("round_robin_slot_allocator_core verification failed");
      $finish;
   end

endmodule
